// File: hw/rtl/whdfe_pkg.sv
// ----------------------------------------------------------------------------
// whdfe_pkg: shared types and constants
// Payload structs, event codes and the command and status bundles that pass
// between the controller and the datapath of the window hit, drag and focus
// engine.
// ----------------------------------------------------------------------------
`default_nettype none

package whdfe_pkg;

	localparam int MAX_WINDOWS = 8;
	localparam int SLOT_W      = $clog2(MAX_WINDOWS);
	localparam int CNT_W       = $clog2(MAX_WINDOWS + 1);
	localparam int RANK_W      = SLOT_W;

	// geometry width: 16-bit edge plus 12-bit size plus insets, signed
	localparam int GW = 19;

	localparam int KEEP_VISIBLE      = 100;
	localparam int CLOSE_RIGHT_INSET = 20;
	localparam int CLOSE_SIZE        = 16;
	localparam int CLOSE_TOP_INSET   = 4;

	localparam int CFG_W = 13;

	typedef enum logic [2:0] {
		CFG_SCREEN_W   = 3'd0,
		CFG_SCREEN_H   = 3'd1,
		CFG_TITLE_H    = 3'd2,
		CFG_MIN_W      = 3'd3,
		CFG_MIN_H      = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		FN_MOUSE   = 2'd0,
		FN_CREATE  = 2'd1,
		FN_DESTROY = 2'd2
	} func_t;

	typedef enum logic [3:0] {
		EV_NONE       = 4'd0,
		EV_MOVED      = 4'd1,
		EV_HELD       = 4'd2,
		EV_RELEASED   = 4'd3,
		EV_CLOSED     = 4'd4,
		EV_DRAG_START = 4'd5,
		EV_FOCUSED    = 4'd6,
		EV_CREATED    = 4'd7,
		EV_FULL       = 4'd8,
		EV_DESTROYED  = 4'd9,
		EV_IGNORED    = 4'd10
	} event_t;

	typedef struct packed {
		logic [1:0]          func;
		logic signed [15:0]  pos_x;
		logic signed [15:0]  pos_y;
		logic                button_down;
		logic [11:0]         size_w;
		logic [11:0]         size_h;
		logic [2:0]          target_slot;
	} req_t;

	typedef struct packed {
		logic [3:0]          event_res;
		logic [2:0]          slot;
		logic signed [15:0]  win_x;
		logic signed [15:0]  win_y;
		logic                focus_valid;
		logic [2:0]          focus_slot;
		logic [3:0]          window_total;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic scan_step;
		logic pick;
		logic exec;
	} cmd_t;

	typedef struct packed {
		logic need_scan;
		logic scan_last;
		logic rsp_busy;
	} sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/whdfe_ctrl.sv
// ----------------------------------------------------------------------------
// whdfe_ctrl: sequencing controller
// Accepts one item, runs the hit scan over all slots when the item needs it,
// then lets the datapath execute once the result register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module whdfe_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              req_valid,
	output logic             req_ready,
	input  whdfe_pkg::sts_t  sts,
	output whdfe_pkg::cmd_t  cmd
);
	import whdfe_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_PICK,
		S_EXEC
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) state_q <= S_DECODE;
				end
				S_DECODE: begin
					state_q <= sts.need_scan ? S_SCAN : S_EXEC;
				end
				S_SCAN: begin
					if (sts.scan_last) state_q <= S_PICK;
				end
				S_PICK: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (!sts.rsp_busy) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		req_ready     = (state_q == S_IDLE);
		cmd.load      = (state_q == S_IDLE) && req_valid;
		cmd.scan_step = (state_q == S_SCAN);
		cmd.pick      = (state_q == S_PICK);
		cmd.exec      = (state_q == S_EXEC) && !sts.rsp_busy;
	end

endmodule

`default_nettype wire

// File: hw/rtl/whdfe_dp.sv
// ----------------------------------------------------------------------------
// whdfe_dp: window table datapath
// Window table, config registers, hit scan, region tests, drag clamping,
// rank update and result register. Region tests read one shared index.
// ----------------------------------------------------------------------------
`default_nettype none

module whdfe_dp (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       cfg_we,
	input  wire [2:0]                 cfg_addr,
	input  wire [whdfe_pkg::CFG_W-1:0] cfg_data,
	input  whdfe_pkg::req_t           req,
	output whdfe_pkg::rsp_t           rsp,
	output logic                      rsp_valid,
	input  wire                       rsp_ready,
	input  whdfe_pkg::cmd_t           cmd,
	output whdfe_pkg::sts_t           sts
);
	import whdfe_pkg::*;

	function automatic logic signed [GW-1:0] sx16(input logic signed [15:0] v);
		return GW'(v);
	endfunction

	// configuration
	logic [12:0] screen_w_q, screen_h_q;
	logic [7:0]  title_h_q;
	logic [11:0] min_w_q, min_h_q;

	// window table
	logic                     live_q  [MAX_WINDOWS];
	logic signed [15:0]       left_q  [MAX_WINDOWS];
	logic signed [15:0]       top_q   [MAX_WINDOWS];
	logic [11:0]              wid_q   [MAX_WINDOWS];
	logic [11:0]              hgt_q   [MAX_WINDOWS];
	logic [RANK_W-1:0]        rank_q  [MAX_WINDOWS];

	logic [CNT_W-1:0]         count_q;
	logic                     drag_q;
	logic [SLOT_W-1:0]        drag_slot_q;
	logic signed [16:0]       grab_dx_q, grab_dy_q;
	logic                     prev_btn_q;
	logic                     focus_q;
	logic [SLOT_W-1:0]        focus_idx_q;

	// per item
	req_t                     item_q;
	logic [SLOT_W-1:0]        idx_q;
	logic                     need_scan_q;
	logic                     found_q;
	logic [SLOT_W-1:0]        best_slot_q;
	logic [RANK_W-1:0]        best_rank_q;
	rsp_t                     rsp_q;
	logic                     rsp_valid_q;

	// entry at the shared index
	logic                     cur_live;
	logic signed [15:0]       cur_left, cur_top;
	logic [11:0]              cur_w, cur_h;
	logic [RANK_W-1:0]        cur_rank;

	logic signed [GW-1:0] px, py, l, r, t, b, tb, bx, by;
	logic in_win, in_title, in_close;

	logic signed [GW-1:0] nx_raw, ny_raw, mx, my, nx_lo, ny_lo, nx, ny;

	logic [SLOT_W-1:0] free_idx;
	logic              free_ok;

	// execute controls
	logic                 dec_en;
	logic                 wr_create;
	logic                 wr_pos;
	logic                 wr_rank;
	logic [RANK_W-1:0]    rank_val;
	logic                 clr_live;
	logic [CNT_W-1:0]     count_d;
	logic                 drag_d;
	logic [SLOT_W-1:0]    drag_slot_d;
	logic                 set_grab;
	logic                 prev_btn_d;
	logic                 focus_d;
	logic [SLOT_W-1:0]    focus_idx_d;
	rsp_t                 rsp_d;
	logic                 clicked;

	assign cur_live = live_q[idx_q];
	assign cur_left = left_q[idx_q];
	assign cur_top  = top_q[idx_q];
	assign cur_w    = wid_q[idx_q];
	assign cur_h    = hgt_q[idx_q];
	assign cur_rank = rank_q[idx_q];

	always_comb begin
		px = sx16(item_q.pos_x);
		py = sx16(item_q.pos_y);
		l  = sx16(cur_left);
		t  = sx16(cur_top);
		r  = l + $signed(GW'(cur_w));
		b  = t + $signed(GW'(cur_h));
		tb = t + $signed(GW'(title_h_q));
		bx = r - GW'(CLOSE_RIGHT_INSET);
		by = t + GW'(CLOSE_TOP_INSET);
		in_win   = (px >= l) && (px < r) && (py >= t) && (py < b);
		in_title = (px >= l) && (px < r) && (py >= t) && (py < tb);
		in_close = (px >= bx) && (px < bx + GW'(CLOSE_SIZE)) &&
			(py >= by) && (py < by + GW'(CLOSE_SIZE));
	end

	// drag position, raised to zero first, then lowered to the bound
	always_comb begin
		nx_raw = px - GW'(grab_dx_q);
		ny_raw = py - GW'(grab_dy_q);
		mx     = $signed(GW'(screen_w_q)) - GW'(KEEP_VISIBLE);
		my     = $signed(GW'(screen_h_q)) - $signed(GW'(title_h_q));
		nx_lo  = (nx_raw < 0) ? '0 : nx_raw;
		ny_lo  = (ny_raw < 0) ? '0 : ny_raw;
		nx     = (nx_lo > mx) ? mx : nx_lo;
		ny     = (ny_lo > my) ? my : ny_lo;
	end

	// lowest free slot
	always_comb begin
		free_idx = '0;
		free_ok  = 1'b0;
		for (int i = MAX_WINDOWS - 1; i >= 0; i--) begin
			if (!live_q[i]) begin
				free_idx = SLOT_W'(i);
				free_ok  = 1'b1;
			end
		end
	end

	assign sts.need_scan = need_scan_q;
	assign sts.scan_last = (idx_q == SLOT_W'(MAX_WINDOWS - 1));
	assign sts.rsp_busy  = rsp_valid_q && !rsp_ready;

	always_comb begin
		dec_en      = 1'b0;
		wr_create   = 1'b0;
		wr_pos      = 1'b0;
		wr_rank     = 1'b0;
		rank_val    = cur_rank;
		clr_live    = 1'b0;
		count_d     = count_q;
		drag_d      = drag_q;
		drag_slot_d = drag_slot_q;
		set_grab    = 1'b0;
		prev_btn_d  = prev_btn_q;
		focus_d     = focus_q;
		focus_idx_d = focus_idx_q;
		clicked     = !item_q.button_down && prev_btn_q;
		rsp_d           = '0;
		rsp_d.event_res = EV_NONE;

		case (item_q.func)
			FN_CREATE: begin
				if (count_q >= CNT_W'(MAX_WINDOWS) || !free_ok) begin
					rsp_d.event_res = EV_FULL;
				end else begin
					wr_create   = 1'b1;
					wr_rank     = 1'b1;
					rank_val    = RANK_W'(count_q);
					count_d     = count_q + 1'b1;
					focus_d     = 1'b1;
					focus_idx_d = idx_q;
					rsp_d.event_res = EV_CREATED;
					rsp_d.slot      = 3'(idx_q);
					rsp_d.win_x     = item_q.pos_x;
					rsp_d.win_y     = item_q.pos_y;
				end
			end
			FN_DESTROY: begin
				if (int'(item_q.target_slot) < MAX_WINDOWS && cur_live) begin
					clr_live = 1'b1;
					dec_en   = 1'b1;
					count_d  = count_q - 1'b1;
					if (focus_q && focus_idx_q == idx_q) begin
						focus_d     = 1'b0;
						focus_idx_d = '0;
					end
					if (drag_q && drag_slot_q == idx_q) begin
						drag_d      = 1'b0;
						drag_slot_d = '0;
					end
					rsp_d.event_res = EV_DESTROYED;
					rsp_d.slot      = 3'(idx_q);
					rsp_d.win_x     = cur_left;
					rsp_d.win_y     = cur_top;
				end else begin
					rsp_d.event_res = EV_IGNORED;
				end
			end
			FN_MOUSE: begin
				if (drag_q) begin
					rsp_d.slot  = 3'(idx_q);
					rsp_d.win_x = cur_left;
					rsp_d.win_y = cur_top;
					if (item_q.button_down) begin
						if (16'(nx) != cur_left || 16'(ny) != cur_top) begin
							wr_pos          = 1'b1;
							rsp_d.event_res = EV_MOVED;
						end else begin
							rsp_d.event_res = EV_HELD;
						end
						rsp_d.win_x = 16'(nx);
						rsp_d.win_y = 16'(ny);
					end else begin
						drag_d          = 1'b0;
						drag_slot_d     = '0;
						rsp_d.event_res = EV_RELEASED;
					end
				end else begin
					prev_btn_d = item_q.button_down;
					if (clicked && found_q && in_close) begin
						clr_live = 1'b1;
						dec_en   = 1'b1;
						count_d  = count_q - 1'b1;
						if (focus_q && focus_idx_q == idx_q) begin
							focus_d     = 1'b0;
							focus_idx_d = '0;
						end
						rsp_d.event_res = EV_CLOSED;
						rsp_d.slot      = 3'(idx_q);
						rsp_d.win_x     = cur_left;
						rsp_d.win_y     = cur_top;
					end
					if (item_q.button_down && found_q) begin
						rsp_d.slot  = 3'(idx_q);
						rsp_d.win_x = cur_left;
						rsp_d.win_y = cur_top;
						// a press on the close box inside the title bar does nothing
						if (!in_title || !in_close) begin
							dec_en      = 1'b1;
							wr_rank     = 1'b1;
							rank_val    = RANK_W'(count_q - 1'b1);
							focus_d     = 1'b1;
							focus_idx_d = idx_q;
							if (in_title) begin
								set_grab        = 1'b1;
								drag_d          = 1'b1;
								drag_slot_d     = idx_q;
								rsp_d.event_res = EV_DRAG_START;
							end else begin
								rsp_d.event_res = EV_FOCUSED;
							end
						end
					end
				end
			end
			default: begin
				rsp_d.event_res = EV_IGNORED;
			end
		endcase

		rsp_d.focus_valid  = focus_d;
		rsp_d.focus_slot   = 3'(focus_idx_d);
		rsp_d.window_total = 4'(count_d);
	end

	// control and small state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_w_q  <= 13'd1024;
			screen_h_q  <= 13'd768;
			title_h_q   <= 8'd24;
			min_w_q     <= 12'd100;
			min_h_q     <= 12'd60;
			for (int i = 0; i < MAX_WINDOWS; i++) live_q[i] <= 1'b0;
			count_q     <= '0;
			drag_q      <= 1'b0;
			drag_slot_q <= '0;
			grab_dx_q   <= '0;
			grab_dy_q   <= '0;
			prev_btn_q  <= 1'b0;
			focus_q     <= 1'b0;
			focus_idx_q <= '0;
			need_scan_q <= 1'b0;
			found_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					CFG_SCREEN_W: screen_w_q <= cfg_data;
					CFG_SCREEN_H: screen_h_q <= cfg_data;
					CFG_TITLE_H:  title_h_q  <= cfg_data[7:0];
					CFG_MIN_W:    min_w_q    <= cfg_data[11:0];
					CFG_MIN_H:    min_h_q    <= cfg_data[11:0];
					default: ;
				endcase
			end

			if (cmd.load) begin
				need_scan_q <= (req.func == FN_MOUSE) && !drag_q &&
					(req.button_down || prev_btn_q);
				found_q <= 1'b0;
			end

			if (cmd.scan_step && cur_live && in_win &&
				(!found_q || cur_rank > best_rank_q)) begin
				found_q <= 1'b1;
			end

			// a new result may replace one taken in the same cycle
			if (cmd.exec) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;

			if (cmd.exec) begin
				if (wr_create) live_q[idx_q] <= 1'b1;
				if (clr_live)  live_q[idx_q] <= 1'b0;
				count_d_apply: begin
					count_q <= count_d;
				end
				drag_q      <= drag_d;
				drag_slot_q <= drag_slot_d;
				if (set_grab) begin
					grab_dx_q <= 17'(px - l);
					grab_dy_q <= 17'(py - t);
				end
				prev_btn_q  <= prev_btn_d;
				focus_q     <= focus_d;
				focus_idx_q <= focus_idx_d;
			end
		end
	end

	// payload registers: table entries, item, scan bookkeeping, result
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= req;
			case (req.func)
				FN_DESTROY: idx_q <= SLOT_W'(req.target_slot);
				FN_CREATE:  idx_q <= free_idx;
				default:    idx_q <= drag_q ? drag_slot_q : '0;
			endcase
		end

		if (cmd.scan_step) begin
			if (cur_live && in_win && (!found_q || cur_rank > best_rank_q)) begin
				best_slot_q <= idx_q;
				best_rank_q <= cur_rank;
			end
			if (idx_q != SLOT_W'(MAX_WINDOWS - 1)) idx_q <= idx_q + 1'b1;
		end

		if (cmd.pick && found_q) idx_q <= best_slot_q;

		if (cmd.exec) begin
			for (int i = 0; i < MAX_WINDOWS; i++) begin
				if (dec_en && live_q[i] && SLOT_W'(i) != idx_q && rank_q[i] > cur_rank)
					rank_q[i] <= rank_q[i] - 1'b1;
			end
			if (wr_rank) rank_q[idx_q] <= rank_val;
			if (wr_create) begin
				left_q[idx_q] <= item_q.pos_x;
				top_q[idx_q]  <= item_q.pos_y;
				wid_q[idx_q]  <= (item_q.size_w < min_w_q) ? min_w_q : item_q.size_w;
				hgt_q[idx_q]  <= (item_q.size_h < min_h_q) ? min_h_q : item_q.size_h;
			end
			if (wr_pos) begin
				left_q[idx_q] <= 16'(nx);
				top_q[idx_q]  <= 16'(ny);
			end
			rsp_q <= rsp_d;
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

endmodule

`default_nettype wire

// File: hw/rtl/window_hit_drag_focus_engine.sv
// Sequence: create, destroy and drag steps go from decode straight to execute;
// a mouse sample needing a hit test scans all slots first, one slot per cycle.
// Throughput: one item at a time; next item accepted the cycle after the result
// is registered, as long as the result register can take it.
// Reset (arst_n low, asynchronous): no live windows, no focus, no drag,
// configuration at its default values. No clearing pass.
// ----------------------------------------------------------------------------
// window_hit_drag_focus_engine: top level
// Window table with hit testing, close box, title bar drag and focus raise.
// ----------------------------------------------------------------------------
`default_nettype none

module window_hit_drag_focus_engine (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        cfg_we,
	input  wire [2:0]                  cfg_addr,
	input  wire [whdfe_pkg::CFG_W-1:0] cfg_data,
	input  wire                        req_valid,
	output logic                       req_ready,
	input  whdfe_pkg::req_t            req,
	output logic                       rsp_valid,
	input  wire                        rsp_ready,
	output whdfe_pkg::rsp_t            rsp
);
	import whdfe_pkg::*;

	cmd_t cmd;
	sts_t sts;

	whdfe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	whdfe_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.req       (req),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

`default_nettype wire

// File: hw/rtl/whdfe_checker.sv
// ----------------------------------------------------------------------------
// whdfe_port_checks: port level checks
// Watches the top level ports for result consistency and handshake rules.
// ----------------------------------------------------------------------------
`default_nettype none

module whdfe_port_checks (
	input wire              clk,
	input wire              arst_n,
	input wire              req_valid,
	input wire              req_ready,
	input wire              rsp_valid,
	input wire              rsp_ready,
	input whdfe_pkg::rsp_t  rsp
);
	import whdfe_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.window_total <= 4'(MAX_WINDOWS))
		else $error("window count out of range");

	a_focus: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.focus_valid |-> rsp.focus_slot == 3'd0)
		else $error("focus slot set without focus");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.event_res == EV_FULL |->
		rsp.window_total == 4'(MAX_WINDOWS) && rsp.slot == 3'd0)
		else $error("full reported with room left");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second transfer taken while item in work");

endmodule

bind window_hit_drag_focus_engine whdfe_port_checks u_whdfe_port_checks (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

`default_nettype wire

// File: tb/whdfe_checker.sv
// ----------------------------------------------------------------------------
// whdfe_checker: result checker for the window hit, drag and focus engine
// Watches the configuration port and both handshake channels. It keeps its
// own copy of the window table and predicts one result per accepted request.
// Each returned result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module whdfe_checker
	import whdfe_pkg::*;
(
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cfg_we,
	input  wire [2:0]          cfg_addr,
	input  wire [CFG_W-1:0]    cfg_data,
	input  wire                req_valid,
	input  wire                req_ready,
	input  req_t               req,
	input  wire                rsp_valid,
	input  wire                rsp_ready,
	input  rsp_t               rsp,
	output int                 errors
);

	int unsigned scr_w, scr_h, title_h, min_w, min_h;

	bit win_live [MAX_WINDOWS];
	int win_l    [MAX_WINDOWS];
	int win_t    [MAX_WINDOWS];
	int win_w    [MAX_WINDOWS];
	int win_h    [MAX_WINDOWS];
	int win_rank [MAX_WINDOWS];
	int n_live;
	bit dragging;
	int drag_idx;
	int grab_x, grab_y;
	bit btn_prev;
	bit focus_on;
	int focus_idx;

	rsp_t expected_rsps[$];
	int mismatches;

	assign errors = mismatches + expected_rsps.size();

	function automatic bit in_box(int s, int x, int y, int h);
		return x >= win_l[s] && x < win_l[s] + win_w[s] &&
			y >= win_t[s] && y < win_t[s] + h;
	endfunction

	function automatic bit in_close_box(int s, int x, int y);
		int bx, by;
		bx = win_l[s] + win_w[s] - CLOSE_RIGHT_INSET;
		by = win_t[s] + CLOSE_TOP_INSET;
		return x >= bx && x < bx + CLOSE_SIZE && y >= by && y < by + CLOSE_SIZE;
	endfunction

	function automatic int topmost_at(int x, int y);
		int best;
		best = -1;
		for (int i = 0; i < MAX_WINDOWS; i++)
			if (win_live[i] && in_box(i, x, y, win_h[i]))
				if (best < 0 || win_rank[i] > win_rank[best])
					best = i;
		return best;
	endfunction

	function automatic void raise_window(int s);
		int old;
		old = win_rank[s];
		for (int i = 0; i < MAX_WINDOWS; i++)
			if (win_live[i] && i != s && win_rank[i] > old)
				win_rank[i]--;
		win_rank[s] = n_live - 1;
		focus_on = 1;
		focus_idx = s;
	endfunction

	function automatic void drop_window(int s);
		int old;
		old = win_rank[s];
		win_live[s] = 0;
		for (int i = 0; i < MAX_WINDOWS; i++)
			if (win_live[i] && win_rank[i] > old)
				win_rank[i]--;
		n_live--;
		if (focus_on && focus_idx == s) begin
			focus_on = 0;
			focus_idx = 0;
		end
		if (dragging && drag_idx == s) begin
			dragging = 0;
			drag_idx = 0;
		end
	endfunction

	function automatic rsp_t predict_event(req_t r);
		rsp_t o;
		int px, py, s, h, nx, ny, mx, my, wx, wy;
		bit clicked;
		o = '0;
		px = int'(r.pos_x);
		py = int'(r.pos_y);
		wx = 0;
		wy = 0;
		case (r.func)
			FN_CREATE: begin
				s = -1;
				for (int i = MAX_WINDOWS - 1; i >= 0; i--)
					if (!win_live[i]) s = i;
				if (n_live >= MAX_WINDOWS || s < 0) begin
					o.event_res = EV_FULL;
				end else begin
					win_live[s] = 1;
					win_l[s] = px;
					win_t[s] = py;
					win_w[s] = (r.size_w < min_w) ? min_w : r.size_w;
					win_h[s] = (r.size_h < min_h) ? min_h : r.size_h;
					win_rank[s] = n_live;
					n_live++;
					raise_window(s);
					o.event_res = EV_CREATED;
					o.slot = 3'(s);
					wx = px;
					wy = py;
				end
			end
			FN_DESTROY: begin
				s = r.target_slot;
				if (win_live[s]) begin
					o.event_res = EV_DESTROYED;
					o.slot = 3'(s);
					wx = win_l[s];
					wy = win_t[s];
					drop_window(s);
				end else begin
					o.event_res = EV_IGNORED;
				end
			end
			FN_MOUSE: begin
				if (dragging) begin
					s = drag_idx;
					o.slot = 3'(s);
					if (r.button_down) begin
						nx = px - grab_x;
						ny = py - grab_y;
						mx = int'(scr_w) - KEEP_VISIBLE;
						my = int'(scr_h) - int'(title_h);
						if (nx < 0) nx = 0;
						if (nx > mx) nx = mx;
						if (ny < 0) ny = 0;
						if (ny > my) ny = my;
						if (nx != win_l[s] || ny != win_t[s]) begin
							win_l[s] = nx;
							win_t[s] = ny;
							o.event_res = EV_MOVED;
						end else begin
							o.event_res = EV_HELD;
						end
					end else begin
						dragging = 0;
						drag_idx = 0;
						o.event_res = EV_RELEASED;
					end
					wx = win_l[s];
					wy = win_t[s];
				end else begin
					// button memory only advances outside a drag
					clicked = !r.button_down && btn_prev;
					btn_prev = r.button_down;
					if (clicked) begin
						h = topmost_at(px, py);
						if (h >= 0 && in_close_box(h, px, py)) begin
							o.event_res = EV_CLOSED;
							o.slot = 3'(h);
							wx = win_l[h];
							wy = win_t[h];
							drop_window(h);
						end
					end
					if (r.button_down) begin
						h = topmost_at(px, py);
						if (h >= 0) begin
							o.slot = 3'(h);
							if (in_box(h, px, py, title_h)) begin
								if (!in_close_box(h, px, py)) begin
									grab_x = px - win_l[h];
									grab_y = py - win_t[h];
									dragging = 1;
									drag_idx = h;
									raise_window(h);
									o.event_res = EV_DRAG_START;
								end
							end else begin
								raise_window(h);
								o.event_res = EV_FOCUSED;
							end
							wx = win_l[h];
							wy = win_t[h];
						end
					end
				end
			end
			default: o.event_res = EV_IGNORED;
		endcase
		o.win_x = wx[15:0];
		o.win_y = wy[15:0];
		o.focus_valid = focus_on;
		o.focus_slot = focus_on ? 3'(focus_idx) : 3'd0;
		o.window_total = 4'(n_live);
		return o;
	endfunction

	task automatic report(string field, int got, int want);
		if (got != want) begin
			$display("%0t mismatch on %s: got %0d, expected %0d", $time, field, got, want);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t e;
		if (!arst_n) begin
			scr_w = 1024; scr_h = 768; title_h = 24; min_w = 100; min_h = 60;
			for (int i = 0; i < MAX_WINDOWS; i++) begin
				win_live[i] = 0; win_l[i] = 0; win_t[i] = 0;
				win_w[i] = 0; win_h[i] = 0; win_rank[i] = 0;
			end
			n_live = 0; dragging = 0; drag_idx = 0; grab_x = 0; grab_y = 0;
			btn_prev = 0; focus_on = 0; focus_idx = 0;
			expected_rsps.delete();
			mismatches = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					CFG_SCREEN_W: scr_w = cfg_data;
					CFG_SCREEN_H: scr_h = cfg_data;
					CFG_TITLE_H:  title_h = cfg_data[7:0];
					CFG_MIN_W:    min_w = cfg_data[11:0];
					CFG_MIN_H:    min_h = cfg_data[11:0];
					default: ;
				endcase
			end
			if (rsp_valid && rsp_ready) begin
				if (expected_rsps.size() == 0) begin
					report("unexpected transfer", 1, 0);
				end else begin
					e = expected_rsps.pop_front();
					report("event_res", rsp.event_res, e.event_res);
					report("slot", rsp.slot, e.slot);
					report("win_x", rsp.win_x, e.win_x);
					report("win_y", rsp.win_y, e.win_y);
					report("focus_valid", rsp.focus_valid, e.focus_valid);
					report("focus_slot", rsp.focus_slot, e.focus_slot);
					report("window_total", rsp.window_total, e.window_total);
				end
			end
			if (req_valid && req_ready)
				expected_rsps.push_back(predict_event(req));
		end
	end

endmodule

`default_nettype wire

// File: tb/tb_window_hit_drag_focus_engine.sv
// ----------------------------------------------------------------------------
// tb_window_hit_drag_focus_engine: stimulus and verdict
// Drives directed and random window events (create, destroy, clicks, drags
// and close-box hits) through four configuration settings with varying
// handshake idling and one long result stall. Checking is done by
// whdfe_checker.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_window_hit_drag_focus_engine;
	import whdfe_pkg::*;

	localparam logic [1:0] FN_BAD = 2'd3;
	localparam int IDLE_LIMIT = 4000;
	localparam int RAND_PER_PHASE = 95;
	localparam int REQ_W = $bits(req_t);

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [2:0] cfg_addr = CFG_SCREEN_W;
	logic [CFG_W-1:0] cfg_data = '0;
	logic req_valid = 0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 0;
	rsp_t rsp;
	int errors;

	int tx_idle = 16;
	int rx_idle = 80;
	bit stall_go = 0;
	bit stall_done = 0;
	int sent = 0;
	int done = 0;
	int idle_cycles = 0;

	// rough view of the window table for aiming the pointer
	bit aim_live [MAX_WINDOWS];
	int aim_l [MAX_WINDOWS];
	int aim_t [MAX_WINDOWS];
	int aim_w [MAX_WINDOWS];
	int aim_h [MAX_WINDOWS];
	int cur_min_w = 100, cur_min_h = 60, cur_title = 24;
	req_t in_flight[$];

	always #5 clk = ~clk;

	window_hit_drag_focus_engine dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	whdfe_checker chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.errors(errors)
	);

	// receiver: random stalls, plus one long hold-off on request
	always begin
		@(negedge clk);
		if (stall_go && !stall_done) begin
			stall_done = 1;
			repeat (400) begin
				rsp_ready = 0;
				@(negedge clk);
			end
		end
		rsp_ready = ($urandom_range(99) >= rx_idle);
	end

	always @(posedge clk) begin
		req_t r;
		int s;
		if (req_valid && req_ready) begin
			sent++;
			in_flight.push_back(req);
		end
		if (rsp_valid && rsp_ready) begin
			done++;
			r = in_flight.pop_front();
			s = rsp.slot;
			case (rsp.event_res)
				EV_CREATED: begin
					aim_live[s] = 1;
					aim_l[s] = rsp.win_x;
					aim_t[s] = rsp.win_y;
					aim_w[s] = (r.size_w < cur_min_w) ? cur_min_w : r.size_w;
					aim_h[s] = (r.size_h < cur_min_h) ? cur_min_h : r.size_h;
				end
				EV_DESTROYED, EV_CLOSED: aim_live[s] = 0;
				EV_MOVED: begin
					aim_l[s] = rsp.win_x;
					aim_t[s] = rsp.win_y;
				end
				default: ;
			endcase
		end
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic send(req_t r);
		while ($urandom_range(99) < tx_idle) begin
			req_valid = 0;
			@(negedge clk);
		end
		req = r;
		req_valid = 1;
		do @(posedge clk); while (!(req_valid && req_ready));
		@(negedge clk);
	endtask

	task automatic mouse(int x, int y, bit btn);
		req_t r;
		r = '0;
		r.func = FN_MOUSE;
		r.pos_x = x[15:0];
		r.pos_y = y[15:0];
		r.button_down = btn;
		r.size_w = 12'($urandom);
		r.size_h = 12'($urandom);
		r.target_slot = 3'($urandom);
		send(r);
	endtask

	task automatic create(int x, int y, int w, int h);
		req_t r;
		r = '0;
		r.func = FN_CREATE;
		r.pos_x = x[15:0];
		r.pos_y = y[15:0];
		r.button_down = 1'($urandom);
		r.size_w = w[11:0];
		r.size_h = h[11:0];
		r.target_slot = 3'($urandom);
		send(r);
	endtask

	task automatic destroy(int s);
		req_t r;
		r = REQ_W'({$urandom, $urandom});
		r.func = FN_DESTROY;
		r.target_slot = s[2:0];
		send(r);
	endtask

	task automatic configure(int sw, int sh, int th, int mw, int mh);
		req_valid = 0;
		while (done != sent) @(negedge clk);
		repeat (16) @(negedge clk);
		cfg_we = 1;
		cfg_addr = CFG_SCREEN_W; cfg_data = CFG_W'(sw); @(negedge clk);
		cfg_addr = CFG_SCREEN_H; cfg_data = CFG_W'(sh); @(negedge clk);
		cfg_addr = CFG_TITLE_H;  cfg_data = CFG_W'(th); @(negedge clk);
		cfg_addr = CFG_MIN_W;    cfg_data = CFG_W'(mw); @(negedge clk);
		cfg_addr = CFG_MIN_H;    cfg_data = CFG_W'(mh); @(negedge clk);
		cfg_we = 0;
		cur_title = th; cur_min_w = mw; cur_min_h = mh;
	endtask

	function automatic int pick_live();
		int cand[$];
		for (int i = 0; i < MAX_WINDOWS; i++)
			if (aim_live[i]) cand.push_back(i);
		if (cand.size() == 0) return -1;
		return cand[$urandom_range(cand.size() - 1)];
	endfunction

	// one random item or well-formed pointer sequence; returns items sent
	task automatic random_step(output int n);
		int s, k, x, y, ax, ay, dice;
		n = 1;
		dice = $urandom_range(99);
		s = pick_live();
		if (s < 0 || dice < 12) begin
			if ($urandom_range(19) == 0)
				create($urandom, $urandom, $urandom, $urandom);
			else
				create($urandom_range(600) - 50, $urandom_range(450) - 50,
					$urandom_range(400), $urandom_range(300));
		end else if (dice < 20) begin
			destroy($urandom_range(7));
		end else if (dice < 24) begin
			req_t r;
			r = REQ_W'({$urandom, $urandom});
			r.func = FN_BAD;
			send(r);
		end else if (dice < 34) begin
			if ($urandom_range(1))
				mouse($urandom, $urandom, 1'($urandom));
			else
				mouse($urandom_range(800) - 100, $urandom_range(600) - 100,
					1'($urandom));
		end else if (dice < 60) begin
			// drag by the title bar
			x = aim_l[s] + $urandom_range((aim_w[s] > 30) ? aim_w[s] - 30 : 0);
			y = aim_t[s] + $urandom_range((cur_title > 1) ? cur_title - 1 : 0);
			mouse(x, y, 1);
			k = $urandom_range(5);
			for (int i = 0; i < k; i++) begin
				if ($urandom_range(3) != 0) begin
					x += $urandom_range(200) - 100;
					y += $urandom_range(200) - 100;
				end
				mouse(x, y, 1);
			end
			mouse(x, y, 0);
			n = k + 2;
		end else if (dice < 80) begin
			// press and release on the close box
			ax = aim_l[s] + aim_w[s] - CLOSE_RIGHT_INSET + $urandom_range(CLOSE_SIZE - 1);
			ay = aim_t[s] + CLOSE_TOP_INSET + $urandom_range(CLOSE_SIZE - 1);
			mouse(ax, ay, 1);
			mouse(ax + $urandom_range(2) - 1, ay + $urandom_range(2) - 1, 0);
			n = 2;
		end else begin
			// click in the body
			x = aim_l[s] + $urandom_range(aim_w[s]);
			y = aim_t[s] + $urandom_range(aim_h[s]);
			mouse(x, y, 1);
			mouse(x, y, 0);
			n = 2;
		end
	endtask

	task automatic random_phase();
		int cnt, n;
		cnt = 0;
		while (cnt < RAND_PER_PHASE) begin
			random_step(n);
			cnt += n;
		end
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: odd codes, empty table, clamps, drag, close, full table
		begin
			req_t r;
			r = '1;
			r.func = FN_BAD;
			send(r);
		end
		destroy(5);
		mouse(0, 0, 0);
		create(50, 50, 0, 0);
		create(-32768, 32767, 4095, 4095);
		create(32767, -32768, 4095, 4095);
		mouse(60, 55, 1);
		mouse(-500, -500, 1);
		mouse(-500, -500, 1);
		mouse(30000, 30000, 1);
		mouse(30000, 30000, 0);
		mouse(30000, 30000, 0);
		mouse(930, 750, 1);
		mouse(1009, 717, 1);
		mouse(1009, 717, 0);
		for (int i = 0; i < 7; i++)
			create(-10 + 40 * i, 20 * i, 150, 120);
		destroy(1);
		destroy(2);

		random_phase();

		configure(1, 1, 255, 0, 0);
		random_phase();

		tx_idle = 80;
		rx_idle = 16;
		configure(4096, 4096, 1, 4095, 4095);
		random_phase();

		tx_idle = 0;
		rx_idle = 0;
		configure(640, 480, 16, 30, 20);
		stall_go = 1;
		random_phase();

		req_valid = 0;
		while (done != sent) @(negedge clk);
		repeat (30) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire

// File: files.f
hw/rtl/whdfe_pkg.sv
hw/rtl/whdfe_ctrl.sv
hw/rtl/whdfe_dp.sv
hw/rtl/window_hit_drag_focus_engine.sv
hw/rtl/whdfe_checker.sv
tb/whdfe_checker.sv
tb/tb_window_hit_drag_focus_engine.sv
